// File: hdl/assert_macros.svh
// assertion helpers included by the checker file pdd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

// File: hdl/pdd_pkg.sv
package pdd_pkg;

	// default sizes
	localparam int MAX_TASKS_DEF     = 16;
	localparam int PRIORITY_BITS_DEF = 8;

	// fixed field widths
	localparam int DEP_W  = 16;
	localparam int IDX_W  = 4;
	localparam int PRIO_W = 8;
	localparam int CFG_W  = 5;
	localparam int PEND_W = 5;

	// request codes
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_DONE  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_DISPATCH = 2'd0;
	localparam logic [1:0] KIND_ALLDONE  = 2'd1;
	localparam logic [1:0] KIND_STALL    = 2'd2;
	localparam logic [1:0] KIND_BAD      = 2'd3;

	// task status codes
	localparam logic [1:0] ST_WAIT = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [IDX_W-1:0]  task_index;
		logic [PRIO_W-1:0] priority_req;
		logic [DEP_W-1:0]  dep_mask;
	} req_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  task_index_res;
		logic [PRIO_W-1:0] task_priority;
		logic              last;
	} res_t;

	// broadcast to every task cell
	typedef struct packed {
		logic              load;
		logic              start;
		logic              finish;
		logic [IDX_W-1:0]  idx;
		logic [DEP_W-1:0]  deps;
	} task_cmd_t;

	// control of the ordered dispatch chain
	typedef struct packed {
		logic ins;
		logic pop;
	} sort_ctl_t;

endpackage

// File: hdl/pdd_task_cell.sv
module pdd_task_cell import pdd_pkg::*; #(
	parameter int CELL_ID       = 0,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  task_cmd_t                cmd,
	input  logic [PRIORITY_BITS-1:0] prio_in,
	input  logic                     active,
	input  logic [DEP_W-1:0]         vm,
	input  logic                     pick,
	output logic                     fresh,
	output logic                     sel_run,
	output logic [PRIORITY_BITS-1:0] prio
);

	logic [DEP_W-1:0]         dep_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PEND_W-1:0]        pend_q;
	logic [1:0]               status_q;
	logic                     fresh_q;
	logic                     hit;
	logic [PEND_W-1:0]        cnt;

	// this cell addressed by the request
	assign hit = (int'(cmd.idx) == CELL_ID);

	// unmet dependencies inside the graph
	assign cnt = PEND_W'($countones(dep_q & vm));

	assign fresh   = fresh_q;
	assign sel_run = hit && (status_q == ST_RUN);
	assign prio    = prio_q;

	// task state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_q    <= '0;
			prio_q   <= '0;
			pend_q   <= '0;
			status_q <= ST_WAIT;
			fresh_q  <= 1'b0;
		end else begin
			if (cmd.load && hit) begin
				dep_q  <= cmd.deps;
				prio_q <= prio_in;
			end
			if (cmd.start) begin
				status_q <= ST_WAIT;
				pend_q   <= active ? cnt : '0;
				fresh_q  <= active && (cnt == '0);
			end else if (cmd.finish) begin
				if (hit) begin
					status_q <= ST_DONE;
				end else if (status_q == ST_WAIT && dep_q[cmd.idx] && pend_q != '0) begin
					pend_q <= pend_q - PEND_W'(1);
					if (pend_q == PEND_W'(1)) begin
						fresh_q <= 1'b1;
					end
				end
			end else if (pick) begin
				fresh_q  <= 1'b0;
				status_q <= ST_RUN;
			end
		end
	end

endmodule

// File: hdl/pdd_sort_cell.sv
module pdd_sort_cell import pdd_pkg::*; #(
	parameter int IW            = 4,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sort_ctl_t                ctl,
	input  logic [IW-1:0]            key_idx,
	input  logic [PRIORITY_BITS-1:0] key_prio,
	input  logic                     prev_ahead,
	input  logic                     prev_valid,
	input  logic [IW-1:0]            prev_idx,
	input  logic [PRIORITY_BITS-1:0] prev_prio,
	input  logic                     next_valid,
	input  logic [IW-1:0]            next_idx,
	input  logic [PRIORITY_BITS-1:0] next_prio,
	output logic                     valid,
	output logic [IW-1:0]            idx,
	output logic [PRIORITY_BITS-1:0] prio,
	output logic                     ahead
);

	logic                     valid_q;
	logic [IW-1:0]            idx_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	// new key ranks behind this entry (ties keep the earlier, lower index)
	assign ahead = valid_q && (prio_q >= key_prio);

	assign valid = valid_q;
	assign idx   = idx_q;
	assign prio  = prio_q;

	// insert with shift toward the tail, or pop toward the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
			prio_q  <= '0;
		end else if (ctl.ins) begin
			if (!ahead) begin
				if (prev_ahead) begin
					valid_q <= 1'b1;
					idx_q   <= key_idx;
					prio_q  <= key_prio;
				end else begin
					valid_q <= prev_valid;
					idx_q   <= prev_idx;
					prio_q  <= prev_prio;
				end
			end
		end else if (ctl.pop) begin
			valid_q <= next_valid;
			idx_q   <= next_idx;
			prio_q  <= next_prio;
		end
	end

endmodule

// File: hdl/priority_dependency_dispatcher.sv
// Dependency-driven task dispatcher. Load beats store a task's priority and
// dependency mask; a start beat counts every task's unmet dependencies and
// dispatches the free ones; a completion beat retires a running task and
// dispatches the tasks it frees. Tasks freed by one beat come out highest
// priority first, lower index first on a tie, the last one flagged. A load
// gives no result. A start or completion first updates the row of task
// cells, then inserts each freed task into the ordered dispatch chain, then
// sees the freed set empty, and then sends one dispatch beat per freed task;
// with nothing freed it ends there, or with an all-done or stall beat. A bad
// request gives a bad-request beat. The chain has a single insertion port,
// so freed tasks enter it one at a time. Output stall holds the beats back.
module priority_dependency_dispatcher import pdd_pkg::*; #(
	parameter int MAX_TASKS     = MAX_TASKS_DEF,
	parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int NW = (CW > CFG_W) ? CW : CFG_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INS  = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]               state_q;
	logic [CFG_W-1:0]         task_count_q;
	logic                     run_q;
	logic [CW-1:0]            finished_q;
	logic [CW-1:0]            running_q;
	logic [1:0]               fin_kind_q;
	logic                     res_valid_q;
	res_t                     res_q;

	logic [NW-1:0]            tc_w;
	logic [NW-1:0]            n_w;
	logic                     idx_ok;
	logic                     all_done;
	logic                     acc;
	logic                     go_load;
	logic                     go_start;
	logic                     go_fin;
	logic                     go_bad;
	logic                     out_free;
	logic                     ins_fire;
	logic                     pop_fire;
	logic                     fin_fire;
	task_cmd_t                cmd;
	sort_ctl_t                sctl;
	logic [PRIORITY_BITS-1:0] load_prio;

	logic [MAX_TASKS-1:0]     active;
	logic [DEP_W-1:0]         vm;
	logic [MAX_TASKS-1:0]     fresh_vec;
	logic [MAX_TASKS-1:0]     sel_run_vec;
	logic [MAX_TASKS-1:0]     pick_vec;
	logic [PRIORITY_BITS-1:0] tprio [MAX_TASKS];
	logic [IW-1:0]            pick_idx;
	logic [PRIORITY_BITS-1:0] pick_prio;

	logic                     s_valid [MAX_TASKS];
	logic [IW-1:0]            s_idx   [MAX_TASKS];
	logic [PRIORITY_BITS-1:0] s_prio  [MAX_TASKS];
	logic                     s_ahead [MAX_TASKS];

	// effective task count, clamped to 1..MAX_TASKS
	always_comb begin
		tc_w = NW'(task_count_q);
		if (tc_w == '0) begin
			n_w = NW'(1);
		end else if (tc_w > NW'(MAX_TASKS)) begin
			n_w = NW'(MAX_TASKS);
		end else begin
			n_w = tc_w;
		end
	end

	assign idx_ok   = NW'(req.task_index) < n_w;
	assign all_done = NW'(finished_q) >= n_w;

	// per-task and per-mask-bit range flags
	for (genvar j = 0; j < MAX_TASKS; j++) begin : g_active
		assign active[j] = NW'(j) < n_w;
	end
	for (genvar k = 0; k < DEP_W; k++) begin : g_vm
		assign vm[k] = NW'(k) < n_w;
	end

	// request decode
	assign req_stall = (state_q != S_IDLE);
	assign acc       = req_valid && !req_stall;
	assign go_load   = acc && req.req_type == REQ_LOAD && !run_q && idx_ok;
	assign go_start  = acc && req.req_type == REQ_START && !run_q;
	assign go_fin    = acc && req.req_type == REQ_DONE && run_q && idx_ok && (|sel_run_vec);
	assign go_bad    = acc && !(go_load || go_start || go_fin);

	always_comb begin
		cmd.load   = go_load;
		cmd.start  = go_start;
		cmd.finish = go_fin;
		cmd.idx    = req.task_index;
		cmd.deps   = req.dep_mask;
	end

	assign load_prio = PRIORITY_BITS'(req.priority_req);

	// lowest-index freed task goes into the chain next
	assign pick_vec = fresh_vec & (~fresh_vec + MAX_TASKS'(1));
	assign ins_fire = (state_q == S_INS) && (|fresh_vec);

	always_comb begin
		pick_idx  = '0;
		pick_prio = '0;
		for (int j = 0; j < MAX_TASKS; j++) begin
			if (pick_vec[j]) begin
				pick_idx  = pick_idx | IW'(j);
				pick_prio = pick_prio | tprio[j];
			end
		end
	end

	// output handshake
	assign out_free = !res_valid_q || !res_stall;
	assign pop_fire = (state_q == S_POP) && out_free && s_valid[0];
	assign fin_fire = (state_q == S_FIN) && out_free;

	always_comb begin
		sctl.ins = ins_fire;
		sctl.pop = pop_fire;
	end

	// row of task cells
	for (genvar j = 0; j < MAX_TASKS; j++) begin : g_task
		pdd_task_cell #(
			.CELL_ID       (j),
			.PRIORITY_BITS (PRIORITY_BITS)
		) u_task (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.prio_in (load_prio),
			.active  (active[j]),
			.vm      (vm),
			.pick    (ins_fire && pick_vec[j]),
			.fresh   (fresh_vec[j]),
			.sel_run (sel_run_vec[j]),
			.prio    (tprio[j])
		);
	end

	// ordered dispatch chain, head at cell 0
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_sort
		logic                     p_ahead;
		logic                     p_valid;
		logic [IW-1:0]            p_idx;
		logic [PRIORITY_BITS-1:0] p_prio;
		logic                     n_valid;
		logic [IW-1:0]            n_idx;
		logic [PRIORITY_BITS-1:0] n_prio;

		if (i == 0) begin : g_head
			assign p_ahead = 1'b1;
			assign p_valid = 1'b0;
			assign p_idx   = '0;
			assign p_prio  = '0;
		end else begin : g_mid
			assign p_ahead = s_ahead[i-1];
			assign p_valid = s_valid[i-1];
			assign p_idx   = s_idx[i-1];
			assign p_prio  = s_prio[i-1];
		end

		if (i == MAX_TASKS - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_idx   = '0;
			assign n_prio  = '0;
		end else begin : g_body
			assign n_valid = s_valid[i+1];
			assign n_idx   = s_idx[i+1];
			assign n_prio  = s_prio[i+1];
		end

		pdd_sort_cell #(
			.IW            (IW),
			.PRIORITY_BITS (PRIORITY_BITS)
		) u_sort (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (sctl),
			.key_idx    (pick_idx),
			.key_prio   (pick_prio),
			.prev_ahead (p_ahead),
			.prev_valid (p_valid),
			.prev_idx   (p_idx),
			.prev_prio  (p_prio),
			.next_valid (n_valid),
			.next_idx   (n_idx),
			.next_prio  (n_prio),
			.valid      (s_valid[i]),
			.idx        (s_idx[i]),
			.prio       (s_prio[i]),
			.ahead      (s_ahead[i])
		);
	end

	// sequencer, run counters and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			task_count_q <= CFG_W'(16);
			run_q        <= 1'b0;
			finished_q   <= '0;
			running_q    <= '0;
			fin_kind_q   <= KIND_BAD;
		end else begin
			if (cfg_valid && !run_q) begin
				task_count_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (go_start) begin
						finished_q <= '0;
						running_q  <= '0;
						run_q      <= 1'b1;
						state_q    <= S_INS;
					end else if (go_fin) begin
						finished_q <= finished_q + CW'(1);
						running_q  <= running_q - CW'(1);
						state_q    <= S_INS;
					end else if (go_bad) begin
						fin_kind_q <= KIND_BAD;
						state_q    <= S_FIN;
					end
				end
				S_INS: begin
					priority if (ins_fire) begin
						running_q <= running_q + CW'(1);
					end else if (s_valid[0]) begin
						state_q <= S_POP;
					end else if (all_done) begin
						fin_kind_q <= KIND_ALLDONE;
						run_q      <= 1'b0;
						state_q    <= S_FIN;
					end else if (running_q == '0) begin
						fin_kind_q <= KIND_STALL;
						run_q      <= 1'b0;
						state_q    <= S_FIN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					if (pop_fire && !s_valid[1]) begin
						state_q <= S_IDLE;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= pop_fire || fin_fire;
		end
	end

	// output register beat
	always_ff @(posedge clk) begin
		if (pop_fire) begin
			res_q.kind           <= KIND_DISPATCH;
			res_q.task_index_res <= IDX_W'(s_idx[0]);
			res_q.task_priority  <= PRIO_W'(s_prio[0]);
			res_q.last           <= !s_valid[1];
		end else if (fin_fire) begin
			res_q.kind           <= fin_kind_q;
			res_q.task_index_res <= '0;
			res_q.task_priority  <= '0;
			res_q.last           <= 1'b1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

endmodule

// File: hdl/pdd_checker.sv
`include "assert_macros.svh"

module pdd_checker import pdd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input req_t             req,
	input logic             res_valid,
	input logic             res_stall,
	input res_t             res,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [CFG_W-1:0] cfg_data
);

	logic req_held;
	logic res_held;
	logic status_beat;
	logic task_data;
	logic cfg_beat;

	assign req_held    = req_valid && req_stall;
	assign res_held    = res_valid && res_stall;
	assign status_beat = res_valid && (res.kind != KIND_DISPATCH);
	assign task_data   = |{res.task_index_res, res.task_priority};
	assign cfg_beat    = cfg_valid && cfg_ready;

	// a stalled request beat holds
	`ASSERT_PROP(a_req_hold, clk, arst_n, req_held |=> req_valid && $stable(req), "stalled req moved")

	// a stalled result beat holds
	`ASSERT_PROP(a_res_hold, clk, arst_n, res_held |=> res_valid && $stable(res), "stalled res moved")

	// all-done, stall and bad-request beats close their item
	`ASSERT_PROP(a_status_last, clk, arst_n, status_beat |-> res.last, "status beat without last")

	// status beats carry no task
	`ASSERT_NEVER(a_status_zero, clk, arst_n, status_beat && task_data, "status beat with task data")

	// a written count is always known
	`ASSERT_NEVER(a_cfg_known, clk, arst_n, cfg_beat && $isunknown(cfg_data), "unknown count write")

endmodule

bind priority_dependency_dispatcher pdd_checker u_pdd_checker (.*);
